>>> hdl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg: shared types and constants of the button click classifier
// Holds the switch count, register indexes, phase and event codes, and the
// result record of the per-switch update unit.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int NUM_SW   = 8;
  localparam int SW_IDX_W = $clog2(NUM_SW);
  localparam int TMR_W    = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;

  // Reset values of the configuration registers.
  localparam logic [TMR_W-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [TMR_W-1:0] LONG_RST     = 16'd800;
  localparam logic [TMR_W-1:0] DOUBLE_RST   = 16'd300;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 3'd0,
    REG_LONG     = 3'd1,
    REG_DOUBLE   = 3'd2,
    REG_ACT_HIGH = 3'd3,
    REG_ENABLE   = 3'd4
  } reg_idx_t;

  // Per-switch click phases.
  typedef enum logic [2:0] {
    PH_IDLE         = 3'd0,
    PH_DEBOUNCE     = 3'd1,
    PH_PRESSED      = 3'd2,
    PH_RELEASED     = 3'd3,
    PH_PRESSED_2    = 3'd4,
    PH_WAIT_RELEASE = 3'd5
  } phase_t;

  // Event kinds reported on the result channel.
  typedef enum logic [1:0] {
    EV_CLICK  = 2'd0,
    EV_DOUBLE = 2'd1,
    EV_LONG   = 2'd2
  } ev_kind_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    SQ_IDLE = 2'd0,
    SQ_SCAN = 2'd1,
    SQ_EMIT = 2'd2
  } seq_state_t;

  // Outcome of one switch update.
  typedef struct packed {
    phase_t            phase;
    logic [TMR_W-1:0]  timer;
    logic              ev_valid;
    ev_kind_t          ev_kind;
  } sw_upd_t;

endpackage

>>> hdl/button_click_classifier.sv
// ----------------------------------------------------------------------------
// button_click_classifier: debounce and click / double / long click detection
// One request is one tick of raw switch levels; every enabled switch is
// advanced through its click machine and the resulting events are reported.
// ----------------------------------------------------------------------------
//
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+------------------------------
// in_      | input     | in_valid / in_ready    | in_pin_levels[7:0]
// out_     | output    | out_valid / out_ready  | out_switch_index, out_event_kind,
//          |           |                        | out_last_event
// cfg_     | input     | cfg_we (no wait)       | cfg_index[2:0], cfg_wdata[15:0]
//
// A tick request is taken while the sequencer is idle; the scan then visits every
// switch in turn (one switch per cycle through the single shared update unit),
// the result slot drains the events one at a time, held while out_ready is low,
// and the sequencer then returns to idle.
// in_ready is high only while the sequencer is idle; a result left waiting in
// the output register does not block the next request from being taken.
// A stall on out_ready holds the sequencer in its emit phase.
// Reset (rst_n low, synchronous) restores the register defaults, parks every
// switch in idle with its timer at zero and empties the output register.
//
module button_click_classifier (
  input  logic                             clk,
  input  logic                             rst_n,
  // Tick requests
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bcc_pkg::NUM_SW-1:0]       in_pin_levels,
  // Events
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bcc_pkg::SW_IDX_W-1:0]     out_switch_index,
  output logic [1:0]                       out_event_kind,
  output logic                             out_last_event,
  // Configuration
  input  logic                             cfg_we,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bcc_pkg::CFG_W-1:0]        cfg_wdata
);

  // Configuration registers.
  logic [bcc_pkg::TMR_W-1:0]  debounce_r;
  logic [bcc_pkg::TMR_W-1:0]  long_r;
  logic [bcc_pkg::TMR_W-1:0]  double_r;
  logic [bcc_pkg::NUM_SW-1:0] act_high_r;
  logic [bcc_pkg::NUM_SW-1:0] enable_r;

  // Per-switch state, one entry per switch.
  bcc_pkg::phase_t            phase_r [bcc_pkg::NUM_SW];
  logic [bcc_pkg::TMR_W-1:0]  timer_r [bcc_pkg::NUM_SW];

  // Sequencer.
  bcc_pkg::seq_state_t        state_r, state_nxt;
  logic [bcc_pkg::SW_IDX_W-1:0] idx_r, idx_nxt;
  logic [bcc_pkg::NUM_SW-1:0] levels_r;

  // Events found during the scan, waiting to be reported in switch order.
  logic [bcc_pkg::NUM_SW-1:0] pend_r, pend_nxt;
  bcc_pkg::ev_kind_t          kind_r [bcc_pkg::NUM_SW];

  // Output register.
  logic                         out_valid_r, out_valid_nxt;
  logic [bcc_pkg::SW_IDX_W-1:0] out_idx_r;
  bcc_pkg::ev_kind_t            out_kind_r;
  logic                         out_last_r;

  bcc_pkg::sw_upd_t             upd;
  logic                         cur_active;
  logic                         slot_free;
  logic                         load_out;
  logic [bcc_pkg::SW_IDX_W-1:0] first_idx;
  logic [bcc_pkg::NUM_SW-1:0]   pend_rest;

  // A switch is active when its level matches its active polarity.
  assign cur_active = (levels_r[idx_r] == act_high_r[idx_r]);

  bcc_unit u_unit (
    .phase               (phase_r[idx_r]),
    .timer               (timer_r[idx_r]),
    .enable              (enable_r[idx_r]),
    .active              (cur_active),
    .debounce_ticks      (debounce_r),
    .long_press_ticks    (long_r),
    .double_window_ticks (double_r),
    .upd                 (upd)
  );

  // Lowest pending switch is reported first.
  always_comb begin
    first_idx = '0;
    for (int k = bcc_pkg::NUM_SW - 1; k >= 0; k--) begin
      if (pend_r[k]) begin
        first_idx = k[bcc_pkg::SW_IDX_W-1:0];
      end
    end
  end

  // Pending set once the lowest entry is taken; empty means this is the last.
  assign pend_rest = pend_r & (pend_r - 1'b1);

  assign slot_free = !out_valid_r || out_ready;
  assign load_out  = (state_r == bcc_pkg::SQ_EMIT) && (pend_r != '0) && slot_free;

  // Sequencer next state.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      bcc_pkg::SQ_IDLE: begin
        if (in_valid) begin
          state_nxt = bcc_pkg::SQ_SCAN;
          idx_nxt   = '0;
          pend_nxt  = '0;
        end
      end
      bcc_pkg::SQ_SCAN: begin
        pend_nxt[idx_r] = upd.ev_valid;
        idx_nxt         = idx_r + 1'b1;
        if (idx_r == bcc_pkg::SW_IDX_W'(bcc_pkg::NUM_SW - 1)) begin
          state_nxt = bcc_pkg::SQ_EMIT;
        end
      end
      bcc_pkg::SQ_EMIT: begin
        if (pend_r == '0) begin
          state_nxt = bcc_pkg::SQ_IDLE;
        end else if (slot_free) begin
          pend_nxt      = pend_rest;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = bcc_pkg::SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bcc_pkg::SQ_IDLE;
      idx_r       <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Captured tick levels and output payload.
  always_ff @(posedge clk) begin
    if (state_r == bcc_pkg::SQ_IDLE && in_valid) begin
      levels_r <= in_pin_levels;
    end
    if (state_r == bcc_pkg::SQ_SCAN) begin
      kind_r[idx_r] <= upd.ev_kind;
    end
    if (load_out) begin
      out_idx_r  <= first_idx;
      out_kind_r <= kind_r[first_idx];
      out_last_r <= (pend_rest == '0);
    end
  end

  // Per-switch state: written back by the update unit during the scan.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < bcc_pkg::NUM_SW; k++) begin
        phase_r[k] <= bcc_pkg::PH_IDLE;
        timer_r[k] <= '0;
      end
    end else if (state_r == bcc_pkg::SQ_SCAN) begin
      phase_r[idx_r] <= upd.phase;
      timer_r[idx_r] <= upd.timer;
    end
  end

  // Configuration writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= bcc_pkg::DEBOUNCE_RST;
      long_r     <= bcc_pkg::LONG_RST;
      double_r   <= bcc_pkg::DOUBLE_RST;
      act_high_r <= '0;
      enable_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bcc_pkg::REG_DEBOUNCE: debounce_r <= cfg_wdata[bcc_pkg::TMR_W-1:0];
        bcc_pkg::REG_LONG:     long_r     <= cfg_wdata[bcc_pkg::TMR_W-1:0];
        bcc_pkg::REG_DOUBLE:   double_r   <= cfg_wdata[bcc_pkg::TMR_W-1:0];
        bcc_pkg::REG_ACT_HIGH: act_high_r <= cfg_wdata[bcc_pkg::NUM_SW-1:0];
        bcc_pkg::REG_ENABLE:   enable_r   <= cfg_wdata[bcc_pkg::NUM_SW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready         = (state_r == bcc_pkg::SQ_IDLE);
  assign out_valid        = out_valid_r;
  assign out_switch_index = out_idx_r;
  assign out_event_kind   = out_kind_r;
  assign out_last_event   = out_last_r;

endmodule

>>> hdl/bcc_unit.sv
// ----------------------------------------------------------------------------
// bcc_unit: shared per-switch update unit
// Decrements one switch timer and advances its click phase for one tick.
// ----------------------------------------------------------------------------
module bcc_unit (
  input  bcc_pkg::phase_t               phase,
  input  logic [bcc_pkg::TMR_W-1:0]     timer,
  input  logic                          enable,
  input  logic                          active,
  input  logic [bcc_pkg::TMR_W-1:0]     debounce_ticks,
  input  logic [bcc_pkg::TMR_W-1:0]     long_press_ticks,
  input  logic [bcc_pkg::TMR_W-1:0]     double_window_ticks,
  output bcc_pkg::sw_upd_t              upd
);

  logic [bcc_pkg::TMR_W-1:0] tmr_dec;
  logic                      expired;

  assign tmr_dec = (timer != '0) ? timer - 1'b1 : timer;
  assign expired = (tmr_dec == '0);

  always_comb begin
    upd.phase    = phase;
    upd.timer    = tmr_dec;
    upd.ev_valid = 1'b0;
    upd.ev_kind  = bcc_pkg::EV_CLICK;
    if (!enable) begin
      // A disabled switch is parked so that enabling it starts cleanly.
      upd.phase = bcc_pkg::PH_IDLE;
      upd.timer = '0;
    end else begin
      case (phase)
        bcc_pkg::PH_DEBOUNCE: begin
          if (!active) begin
            upd.phase = bcc_pkg::PH_IDLE;
          end else if (expired) begin
            upd.timer = long_press_ticks;
            upd.phase = bcc_pkg::PH_PRESSED;
          end
        end
        bcc_pkg::PH_PRESSED: begin
          if (!active) begin
            upd.timer = double_window_ticks;
            upd.phase = bcc_pkg::PH_RELEASED;
          end else if (expired) begin
            upd.ev_valid = 1'b1;
            upd.ev_kind  = bcc_pkg::EV_LONG;
            upd.phase    = bcc_pkg::PH_WAIT_RELEASE;
          end
        end
        bcc_pkg::PH_RELEASED: begin
          if (active) begin
            upd.timer = long_press_ticks;
            upd.phase = bcc_pkg::PH_PRESSED_2;
          end else if (expired) begin
            upd.ev_valid = 1'b1;
            upd.ev_kind  = bcc_pkg::EV_CLICK;
            upd.phase    = bcc_pkg::PH_IDLE;
          end
        end
        bcc_pkg::PH_PRESSED_2: begin
          if (!active) begin
            upd.ev_valid = 1'b1;
            upd.ev_kind  = bcc_pkg::EV_DOUBLE;
            upd.phase    = bcc_pkg::PH_IDLE;
          end else if (expired) begin
            upd.ev_valid = 1'b1;
            upd.ev_kind  = bcc_pkg::EV_LONG;
            upd.phase    = bcc_pkg::PH_WAIT_RELEASE;
          end
        end
        bcc_pkg::PH_WAIT_RELEASE: begin
          if (!active) begin
            upd.phase = bcc_pkg::PH_IDLE;
          end
        end
        default: begin
          // Idle, and any code with no meaning, behaves as idle.
          upd.phase = bcc_pkg::PH_IDLE;
          if (active) begin
            upd.timer = debounce_ticks;
            upd.phase = bcc_pkg::PH_DEBOUNCE;
          end
        end
      endcase
    end
  end

endmodule
